// ===== sv/spfd_pkg.sv =====
// Shared types and constants for the SysEx patch frame decoder.
// Used by every module of the block but the FIFO; depends on nothing.
package spfd_pkg;

  // Byte position counter, saturating at its all-ones value.
  localparam int POS_W = 11;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  localparam logic [7:0] SX_START = 8'hF0;
  localparam logic [7:0] SX_END   = 8'hF7;

  // A message shorter than this many bytes is reported as short.
  localparam int MIN_LEN = 8;
  // Position of the name length byte and of the first name byte.
  localparam int NAME_LEN_POS = 4;
  localparam int NAME_BASE    = 5;
  // Bytes per packed 32-bit word and the phase that completes a word.
  localparam int WORD_BYTES = 5;
  localparam logic [2:0] PHASE_LAST = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MANUF  = 2'd0;
  localparam logic [1:0] CFG_DEVICE = 2'd1;
  localparam logic [1:0] CFG_CMD    = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_NAME   = 2'd0;
  localparam logic [1:0] KIND_WORD   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_SHORT     = 4'd1,
    ST_START     = 4'd2,
    ST_MANUF     = 4'd3,
    ST_DEVICE    = 4'd4,
    ST_COMMAND   = 4'd5,
    ST_END       = 4'd6,
    ST_NAMELEN   = 4'd7,
    ST_TRUNCATED = 4'd8,
    ST_CHECKSUM  = 4'd9
  } status_t;

  // Header fault bits.
  localparam int FAULT_START  = 0;
  localparam int FAULT_MANUF  = 1;
  localparam int FAULT_DEVICE = 2;
  localparam int FAULT_CMD    = 3;

  typedef enum logic [1:0] {
    CS_NONE  = 2'd0,
    CS_MATCH = 2'd1,
    CS_BAD   = 2'd2
  } cs_t;

  // What the back end must do with a byte.
  typedef enum logic [3:0] {
    OP_HDR_START,
    OP_HDR_MANUF,
    OP_HDR_DEVICE,
    OP_HDR_CMD,
    OP_NAME,
    OP_DATA,
    OP_CHECK,
    OP_SKIP,
    OP_LAST
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    logic [7:0] name_index;
    logic       short_msg;
    logic       name_bad;
  } op_entry_t;

  typedef struct packed {
    logic [6:0] manuf;
    logic [6:0] device;
    logic [6:0] command;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  index;
    logic [31:0] value;
    logic [3:0]  status;
  } result_t;

endpackage

// ===== sv/spfd_fifo.sv =====
// Small first-in first-out queue of register entries.
// Generic in width and depth; no package dependency.
module spfd_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_FULL);
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== sv/spfd_front.sv =====
// Front end: accepts message bytes and classifies each by its position.
// Depends on spfd_pkg.
module spfd_front #(
  parameter int NAME_MAX   = 16,
  parameter int WORD_COUNT = 215
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic [7:0]          in_byte,
  input  logic                in_is_last,
  output logic                full,
  input  logic                q_full,
  output logic                q_push,
  output spfd_pkg::op_entry_t q_data
);
  import spfd_pkg::*;

  localparam int DataBytes = WORD_BYTES * WORD_COUNT;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       name_len_r, name_len_nxt;
  logic [POS_W-1:0] name_end, data_end;
  logic             name_bad, accept;

  assign full     = q_full;
  assign accept   = push & ~q_full;
  assign q_push   = accept;
  assign name_bad = (name_len_r > 8'(NAME_MAX));
  assign name_end = POS_W'(NAME_BASE) + POS_W'(name_len_r);
  assign data_end = name_end + POS_W'(DataBytes);

  // The checksum byte sits at exactly one position, so it is taken once.
  always_comb begin
    q_data.data       = in_byte;
    q_data.name_index = pos_r[7:0] - 8'(NAME_BASE);
    q_data.short_msg  = (pos_r < POS_W'(MIN_LEN - 1));
    q_data.name_bad   = name_bad;
    if (in_is_last) begin
      q_data.op = OP_LAST;
    end else if (pos_r == POS_W'(0)) begin
      q_data.op = OP_HDR_START;
    end else if (pos_r == POS_W'(1)) begin
      q_data.op = OP_HDR_MANUF;
    end else if (pos_r == POS_W'(2)) begin
      q_data.op = OP_HDR_DEVICE;
    end else if (pos_r == POS_W'(3)) begin
      q_data.op = OP_HDR_CMD;
    end else if (pos_r == POS_W'(NAME_LEN_POS) || name_bad) begin
      q_data.op = OP_SKIP;
    end else if (pos_r < name_end) begin
      q_data.op = OP_NAME;
    end else if (pos_r < data_end) begin
      q_data.op = OP_DATA;
    end else if (pos_r == data_end) begin
      q_data.op = OP_CHECK;
    end else begin
      q_data.op = OP_SKIP;
    end
  end

  always_comb begin
    pos_nxt      = pos_r;
    name_len_nxt = name_len_r;
    if (accept) begin
      if (in_is_last) begin
        pos_nxt      = '0;
        name_len_nxt = '0;
      end else begin
        if (pos_r == POS_W'(NAME_LEN_POS)) begin
          name_len_nxt = in_byte;
        end
        if (pos_r != POS_MAX) begin
          pos_nxt = pos_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      name_len_r <= '0;
    end else begin
      pos_r      <= pos_nxt;
      name_len_r <= name_len_nxt;
    end
  end

endmodule

// ===== sv/spfd_back.sv =====
// Back end: header checks, word assembly, checksum and final status.
// Depends on spfd_pkg.
module spfd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  spfd_pkg::cfg_t      cfg,
  input  logic                q_empty,
  input  spfd_pkg::op_entry_t q_data,
  output logic                q_pop,
  input  logic                r_full,
  output logic                r_push,
  output spfd_pkg::result_t   r_data
);
  import spfd_pkg::*;

  logic [3:0]  faults_r, faults_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic [2:0]  phase_r, phase_nxt;
  logic [7:0]  wcnt_r, wcnt_nxt;
  logic [6:0]  xor_r, xor_nxt;
  cs_t         cs_r, cs_nxt;
  status_t     fin_status;
  logic        go;

  assign go    = ~q_empty & ~r_full;
  assign q_pop = go;

  // Final status follows a fixed priority order.
  always_comb begin
    if (q_data.short_msg) begin
      fin_status = ST_SHORT;
    end else if (faults_r[FAULT_START]) begin
      fin_status = ST_START;
    end else if (faults_r[FAULT_MANUF]) begin
      fin_status = ST_MANUF;
    end else if (faults_r[FAULT_DEVICE]) begin
      fin_status = ST_DEVICE;
    end else if (faults_r[FAULT_CMD]) begin
      fin_status = ST_COMMAND;
    end else if (q_data.data != SX_END) begin
      fin_status = ST_END;
    end else if (q_data.name_bad) begin
      fin_status = ST_NAMELEN;
    end else if (cs_r == CS_NONE) begin
      fin_status = ST_TRUNCATED;
    end else if (cs_r == CS_BAD) begin
      fin_status = ST_CHECKSUM;
    end else begin
      fin_status = ST_OK;
    end
  end

  always_comb begin
    faults_nxt = faults_r;
    shift_nxt  = shift_r;
    phase_nxt  = phase_r;
    wcnt_nxt   = wcnt_r;
    xor_nxt    = xor_r;
    cs_nxt     = cs_r;
    r_push     = 1'b0;
    r_data     = '0;
    case (q_data.op)
      OP_HDR_START: begin
        if (q_data.data != SX_START) faults_nxt[FAULT_START] = 1'b1;
      end
      OP_HDR_MANUF: begin
        if (q_data.data != {1'b0, cfg.manuf}) faults_nxt[FAULT_MANUF] = 1'b1;
      end
      OP_HDR_DEVICE: begin
        if (q_data.data != {1'b0, cfg.device}) faults_nxt[FAULT_DEVICE] = 1'b1;
      end
      OP_HDR_CMD: begin
        if (q_data.data != {1'b0, cfg.command}) faults_nxt[FAULT_CMD] = 1'b1;
      end
      OP_NAME: begin
        r_push       = go;
        r_data.kind  = KIND_NAME;
        r_data.index = q_data.name_index;
        r_data.value = {24'd0, q_data.data};
      end
      OP_DATA: begin
        xor_nxt = xor_r ^ q_data.data[6:0];
        if (phase_r == 3'd0) begin
          shift_nxt = {28'd0, q_data.data[3:0]};
        end else begin
          shift_nxt = {shift_r[24:0], q_data.data[6:0]};
        end
        if (phase_r >= PHASE_LAST) begin
          r_push       = go;
          r_data.kind  = KIND_WORD;
          r_data.index = wcnt_r;
          r_data.value = shift_nxt;
          wcnt_nxt     = wcnt_r + 1'b1;
          phase_nxt    = '0;
        end else begin
          phase_nxt = phase_r + 1'b1;
        end
      end
      OP_CHECK: begin
        cs_nxt = (q_data.data == {1'b0, xor_r}) ? CS_MATCH : CS_BAD;
      end
      OP_LAST: begin
        r_push        = go;
        r_data.kind   = KIND_STATUS;
        r_data.status = fin_status;
        faults_nxt    = '0;
        shift_nxt     = '0;
        phase_nxt     = '0;
        wcnt_nxt      = '0;
        xor_nxt       = '0;
        cs_nxt        = CS_NONE;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      faults_r <= '0;
      shift_r  <= '0;
      phase_r  <= '0;
      wcnt_r   <= '0;
      xor_r    <= '0;
      cs_r     <= CS_NONE;
    end else if (go) begin
      faults_r <= faults_nxt;
      shift_r  <= shift_nxt;
      phase_r  <= phase_nxt;
      wcnt_r   <= wcnt_nxt;
      xor_r    <= xor_nxt;
      cs_r     <= cs_nxt;
    end
  end

endmodule

// ===== sv/sysex_patch_frame_decoder.sv =====
// Top level of the SysEx patch frame decoder: configuration registers,
// front end, operation queue, back end and result queue.
// Depends on spfd_pkg, spfd_front, spfd_fifo and spfd_back.
//
// Usage. Message bytes enter through a queue-style port: a byte and its
// last-byte flag are transferred at a rising edge where push is high and
// full is low. Results leave the same way: while empty is low the oldest
// result is on the out_ ports, and it is transferred at an edge where pop
// is high. Each name character and each completed 32-bit word gives one
// result; the last byte of a message gives only a status result, and the
// consumer discards the message when that status is not zero.
// The front end classifies every byte by its position in the message and
// passes it through a two-entry queue to the back end, which checks the
// header, assembles words, keeps the checksum and builds results into a
// two-entry result queue. A byte that gives a result is registered in the
// operation queue, and the back end writes its result into the result
// queue ahead of the out_ ports. One byte is taken every cycle as long as
// results are drained every cycle; that rate is set by the back end, which
// retires one queued byte per cycle. When the receiver stalls, bytes keep
// flowing until the result queue is full; the back end then stops and full
// rises after at most two more transfers. No result is lost. Reset (rst_n
// low at a clock edge) empties both queues, clears all message state and
// sets the three ID registers to zero. The ID registers are written
// through cfg_we, cfg_index and cfg_data.
module sysex_patch_frame_decoder #(
  parameter int NAME_MAX   = 16,
  parameter int WORD_COUNT = 215
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  input  logic        in_is_last,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_item_index,
  output logic [31:0] out_item_value,
  output logic [3:0]  out_status,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);
  import spfd_pkg::*;

  localparam int OpW  = $bits(op_entry_t);
  localparam int ResW = $bits(result_t);

  cfg_t      cfg_r, cfg_nxt;
  op_entry_t front_entry, back_entry;
  result_t   back_result, out_result;
  logic      q_push, q_full, q_pop, q_empty;
  logic      r_push, r_full;

  // Users must make register writes with no message in flight; unenforced.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_MANUF:  cfg_nxt.manuf   = cfg_data;
        CFG_DEVICE: cfg_nxt.device  = cfg_data;
        CFG_CMD:    cfg_nxt.command = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  spfd_front #(
    .NAME_MAX  (NAME_MAX),
    .WORD_COUNT(WORD_COUNT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .in_byte   (in_byte),
    .in_is_last(in_is_last),
    .full      (full),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (front_entry)
  );

  spfd_fifo #(
    .W    (OpW),
    .DEPTH(2)
  ) u_op_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata(front_entry),
    .full (q_full),
    .pop  (q_pop),
    .rdata(back_entry),
    .empty(q_empty)
  );

  spfd_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .q_empty(q_empty),
    .q_data (back_entry),
    .q_pop  (q_pop),
    .r_full (r_full),
    .r_push (r_push),
    .r_data (back_result)
  );

  spfd_fifo #(
    .W    (ResW),
    .DEPTH(2)
  ) u_res_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (r_push),
    .wdata(back_result),
    .full (r_full),
    .pop  (pop),
    .rdata(out_result),
    .empty(empty)
  );

  assign out_kind       = out_result.kind;
  assign out_item_index = out_result.index;
  assign out_item_value = out_result.value;
  assign out_status     = out_result.status;

endmodule

// ===== sv/spfd_checker.sv =====
// Port-level checks on the result side of the SysEx patch frame decoder,
// bound to the top level. Depends on spfd_pkg.
module spfd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        empty,
  input logic [1:0]  out_kind,
  input logic [7:0]  out_item_index,
  input logic [31:0] out_item_value,
  input logic [3:0]  out_status
);
  import spfd_pkg::*;

  // Reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  a_kind_valid: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_kind == KIND_NAME || out_kind == KIND_WORD ||
                out_kind == KIND_STATUS))
    else $error("undefined result kind");

  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_kind == KIND_STATUS) |->
      (out_item_index == 8'd0 && out_item_value == 32'd0 &&
       out_status <= ST_CHECKSUM))
    else $error("malformed status result");

  a_item_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_kind != KIND_STATUS) |-> out_status == ST_OK)
    else $error("name or word result carries a status");

  a_name_value_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_kind == KIND_NAME) |-> out_item_value[31:8] == 24'd0)
    else $error("name result wider than a byte");

endmodule

bind sysex_patch_frame_decoder spfd_checker u_spfd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .empty         (empty),
  .out_kind      (out_kind),
  .out_item_index(out_item_index),
  .out_item_value(out_item_value),
  .out_status    (out_status)
);

// ===== tb/tb.sv =====
// Self-checking testbench for the SysEx patch frame decoder (sysex_patch_frame_decoder).
// It depends only on the RTL and on spfd_pkg, from which it takes the result types and
// codes. A byte-level model of the parser inside this file predicts every result.
module tb;
  import spfd_pkg::*;

  // The decoder is built with its standard sizes; the model below uses the same values.
  localparam int NAME_MAX   = 16;
  localparam int WORD_COUNT = 215;

  // A write to the spare register index must change nothing.
  localparam logic [1:0] CFG_SPARE = 2'd3;

  // A byte and then its result are registered in the operation and result queues, and
  // each queue holds two entries, so this many quiet cycles leave the decoder idle.
  localparam int SETTLE_CYCLES = 8;
  // Bytes sent over the whole run; the random messages fill up to this count.
  localparam int RUN_ITEMS     = 1900;
  localparam int NO_FAULT      = -1;
  localparam int WHOLE_MESSAGE = -1;

  typedef enum int {SUM_GOOD, SUM_WRONG, SUM_HIGH_BIT} sum_mode_e;
  typedef enum int {RX_FREE, RX_RANDOM, RX_PATTERN, RX_LONG_STALL} rx_mode_e;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        push       = 1'b0;
  logic [7:0]  in_byte    = '0;
  logic        in_is_last = 1'b0;
  logic        pop        = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_index  = CFG_MANUF;
  logic [6:0]  cfg_data   = '0;
  logic        full;
  logic        empty;
  logic [1:0]  out_kind;
  logic [7:0]  out_item_index;
  logic [31:0] out_item_value;
  logic [3:0]  out_status;

  sysex_patch_frame_decoder #(
    .NAME_MAX  (NAME_MAX),
    .WORD_COUNT(WORD_COUNT)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_byte       (in_byte),
    .in_is_last    (in_is_last),
    .empty         (empty),
    .pop           (pop),
    .out_kind      (out_kind),
    .out_item_index(out_item_index),
    .out_item_value(out_item_value),
    .out_status    (out_status),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------------------
  // Parser model. It mirrors the decoder's message state and ID registers, and is advanced
  // once for every byte that the decoder accepts.
  // ---------------------------------------------------------------------------------------
  cfg_t        ids;
  logic [10:0] msg_pos;
  logic [7:0]  name_len;
  logic [3:0]  hdr_faults;
  logic [31:0] word_acc;
  logic [2:0]  grp_phase;
  logic [7:0]  words_done;
  logic [6:0]  xor_sum;
  cs_t         chk_state;

  result_t expected_results[$];
  int      failures   = 0;
  int      bytes_sent = 0;
  int      burst_left = 0;

  function automatic void clear_message();
    msg_pos    = '0;
    name_len   = '0;
    hdr_faults = '0;
    word_acc   = '0;
    grp_phase  = '0;
    words_done = '0;
    xor_sum    = '0;
    chk_state  = CS_NONE;
  endfunction

  // Advances the model by one byte. Returns 1 when the byte gives a result, which is then
  // left in r.
  function automatic bit predict_byte(input logic [7:0] b, input logic last,
                                      output result_t r);
    logic [10:0] pos;
    logic [10:0] rel;
    status_t     st;
    bit          got;
    pos = msg_pos;
    got = 1'b0;
    r   = '0;
    // The last byte closes the message: only a status comes out, chosen by the first
    // failed check in a fixed order, and the message state starts afresh.
    if (last) begin
      if (int'(pos) + 1 < MIN_LEN) st = ST_SHORT;
      else if (hdr_faults[FAULT_START]) st = ST_START;
      else if (hdr_faults[FAULT_MANUF]) st = ST_MANUF;
      else if (hdr_faults[FAULT_DEVICE]) st = ST_DEVICE;
      else if (hdr_faults[FAULT_CMD]) st = ST_COMMAND;
      else if (b != SX_END) st = ST_END;
      else if (name_len > NAME_MAX) st = ST_NAMELEN;
      else if (chk_state == CS_NONE) st = ST_TRUNCATED;
      else if (chk_state == CS_BAD) st = ST_CHECKSUM;
      else st = ST_OK;
      r.kind   = KIND_STATUS;
      r.status = st;
      clear_message();
      return 1'b1;
    end
    // ID bytes are compared in full eight bits against the seven-bit IDs, so an ID byte
    // with its top bit set never matches.
    case (pos)
      11'd0: if (b != SX_START) hdr_faults[FAULT_START] = 1'b1;
      11'd1: if (b != {1'b0, ids.manuf}) hdr_faults[FAULT_MANUF] = 1'b1;
      11'd2: if (b != {1'b0, ids.device}) hdr_faults[FAULT_DEVICE] = 1'b1;
      11'd3: if (b != {1'b0, ids.command}) hdr_faults[FAULT_CMD] = 1'b1;
      11'(NAME_LEN_POS): name_len = b;
      default: begin
        // An oversized name length silences the rest of the message.
        if (name_len <= NAME_MAX) begin
          if (pos < NAME_BASE + name_len) begin
            rel      = pos - 11'(NAME_BASE);
            r.kind   = KIND_NAME;
            r.index  = rel[7:0];
            r.value  = {24'h0, b};
            got      = 1'b1;
          end else if (words_done < WORD_COUNT) begin
            xor_sum = xor_sum ^ b[6:0];
            if (grp_phase == 3'd0) word_acc = {28'h0, b[3:0]};
            else word_acc = {word_acc[24:0], b[6:0]};
            if (grp_phase >= PHASE_LAST) begin
              r.kind     = KIND_WORD;
              r.index    = words_done;
              r.value    = word_acc;
              got        = 1'b1;
              words_done = words_done + 8'd1;
              grp_phase  = '0;
            end else begin
              grp_phase = grp_phase + 3'd1;
            end
          end else if (chk_state == CS_NONE) begin
            // Only the first byte after the words counts; later ones are ignored.
            chk_state = (b == {1'b0, xor_sum}) ? CS_MATCH : CS_BAD;
          end
        end
      end
    endcase
    // The position counter sticks at its top value rather than wrapping into the header.
    if (pos != POS_MAX) msg_pos = pos + 11'd1;
    return got;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Result checking. Every result transfer is matched against the oldest prediction.
  // ---------------------------------------------------------------------------------------
  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] seen);
    if (want !== seen) begin
      $error("%s mismatch: expected %0d, actual %0d", field, want, seen);
      failures++;
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst_n && pop && !empty) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: kind %0d index %0d value %0d status %0d",
               out_kind, out_item_index, out_item_value, out_status);
        failures++;
      end else begin
        want = expected_results.pop_front();
        check_field("kind", want.kind, out_kind);
        check_field("item_index", want.index, out_item_index);
        check_field("item_value", want.value, out_item_value);
        check_field("status", want.status, out_status);
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Receiver. It switches between free flow, random stalls, a rotating stall pattern and
  // long stalls, so that back pressure reaches both internal queues.
  // ---------------------------------------------------------------------------------------
  rx_mode_e   rx_mode = RX_FREE;
  int         rx_left = 0;
  logic [7:0] rx_mask = 8'hFF;

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(10, 200);
      rx_mask = 8'($urandom_range(1, 255));
    end
    rx_left--;
    case (rx_mode)
      RX_FREE:   pop <= 1'b1;
      RX_RANDOM: pop <= ($urandom_range(0, 3) != 0);
      RX_PATTERN: begin
        pop <= rx_mask[0];
        rx_mask = {rx_mask[0], rx_mask[7:1]};
      end
      default:   pop <= (rx_left % 41 == 0);
    endcase
  end

  // ---------------------------------------------------------------------------------------
  // Sender. Bytes go out in bursts of random length; most bursts are preceded by a gap.
  // A byte is transferred at the first rising edge where push is high and full is low.
  // ---------------------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic last);
    result_t r;
    int      gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 12);
    end
    burst_left--;
    if (gap > 0) begin
      @(negedge clk);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    push       <= 1'b1;
    in_byte    <= b;
    in_is_last <= last;
    do @(posedge clk); while (full);
    if (predict_byte(b, last, r)) expected_results.insert(expected_results.size(), r);
    bytes_sent++;
  endtask

  // Lowers push and lets every outstanding result drain before the decoder is touched.
  task automatic wait_idle();
    @(negedge clk);
    push <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes are only issued while the decoder is idle.
  task automatic write_reg(input logic [1:0] idx, input logic [6:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      CFG_MANUF:  ids.manuf   = data;
      CFG_DEVICE: ids.device  = data;
      CFG_CMD:    ids.command = data;
      default:    ;
    endcase
  endtask

  task automatic set_ids(input logic [6:0] manuf, input logic [6:0] device,
                         input logic [6:0] command);
    write_reg(CFG_MANUF, manuf);
    write_reg(CFG_DEVICE, device);
    write_reg(CFG_CMD, command);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [6:0] pick_id();
    case ($urandom_range(0, 3))
      0:       return 7'h00;
      1:       return 7'h7F;
      default: return 7'($urandom_range(0, 127));
    endcase
  endfunction

  // Builds a patch message for the current IDs and sends it. The name length byte carries
  // name_n and that many name bytes follow. A header byte may be spoilt, the checksum made
  // good or bad, trailing bytes added, and the body cut short before the closing byte.
  task automatic send_patch(input int name_n, input int cut, input int trail_n,
                            input sum_mode_e sum_mode, input int fault_pos,
                            input logic [7:0] tail);
    logic [7:0] body[$];
    logic [7:0] v;
    logic [6:0] sum;
    sum = '0;
    body.insert(body.size(), SX_START);
    body.insert(body.size(), {1'b0, ids.manuf});
    body.insert(body.size(), {1'b0, ids.device});
    body.insert(body.size(), {1'b0, ids.command});
    if (fault_pos != NO_FAULT) body[fault_pos] = body[fault_pos] ^ 8'($urandom_range(1, 255));
    body.insert(body.size(), 8'(name_n));
    repeat (name_n) body.insert(body.size(), 8'($urandom_range(0, 255)));
    repeat (WORD_COUNT * WORD_BYTES) begin
      v   = 8'($urandom_range(0, 255));
      sum = sum ^ v[6:0];
      body.insert(body.size(), v);
    end
    case (sum_mode)
      SUM_GOOD:     body.insert(body.size(), {1'b0, sum});
      SUM_HIGH_BIT: body.insert(body.size(), {1'b1, sum});
      default:      body.insert(body.size(), {1'b0, sum ^ 7'($urandom_range(1, 127))});
    endcase
    repeat (trail_n) body.insert(body.size(), 8'($urandom_range(0, 255)));
    if (cut != WHOLE_MESSAGE) begin
      while (body.size() > cut) void'(body.pop_back());
    end
    foreach (body[i]) send_byte(body[i], 1'b0);
    send_byte(tail, 1'b1);
  endtask

  // ---------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------

  // Short hand-made messages with the IDs at their reset value of zero: a message that is
  // only its closing byte, a bad start byte that outranks every other fault together with
  // an oversized name length, a manufacturer byte with its top bit set under a name of the
  // largest allowed length, and one complete word followed by a wrong closing byte.
  task automatic test_directed();
    logic [8:0] script[$];
    script = '{
      {1'b1, SX_END},
      9'h0FF, 9'h07F, 9'h07F, 9'h07F, 9'h011, 9'h000, 9'h000, 9'h100,
      {1'b0, SX_START}, 9'h080, 9'h000, 9'h000, 9'h010, 9'h0FF, 9'h000, {1'b1, SX_END},
      {1'b0, SX_START}, 9'h000, 9'h000, 9'h000, 9'h001, 9'h041,
      9'h08F, 9'h0FF, 9'h080, 9'h07F, 9'h000, {1'b1, SX_START}
    };
    foreach (script[i]) send_byte(script[i][7:0], script[i][8]);
  endtask

  // IDs at opposite extremes, and a write to the spare index which must be ignored.
  task automatic test_register_extremes();
    wait_idle();
    write_reg(CFG_MANUF, 7'h7F);
    write_reg(CFG_DEVICE, 7'h00);
    write_reg(CFG_CMD, 7'h7F);
    write_reg(CFG_SPARE, 7'h55);
    @(negedge clk);
    cfg_we <= 1'b0;
    // A fault on each ID in turn shows that every register took its value.
    send_patch(2, 12, 0, SUM_GOOD, 1, SX_END);
    send_patch(2, 12, 0, SUM_GOOD, 2, SX_END);
    send_patch(2, 12, 0, SUM_GOOD, 3, SX_END);
  endtask

  // A complete, correct message with the longest name and a few trailing bytes after the
  // checksum; the trailing bytes are ignored and the message closes with a good status.
  task automatic test_long_message();
    wait_idle();
    set_ids(7'h00, 7'h7F, 7'h2A);
    send_patch(NAME_MAX, WHOLE_MESSAGE, 3, SUM_GOOD, NO_FAULT, SX_END);
  endtask

  // Mostly well-formed messages cut at random points, with header faults, oversized name
  // lengths, wrong closing bytes and noise mixed in. The IDs are changed every few
  // messages.
  task automatic test_random_messages();
    int msgs;
    int sel;
    int name_n;
    msgs = 0;
    while (bytes_sent < RUN_ITEMS) begin
      if (msgs % 6 == 5) begin
        wait_idle();
        set_ids(pick_id(), pick_id(), pick_id());
      end
      sel    = $urandom_range(0, 99);
      name_n = $urandom_range(0, NAME_MAX);
      if (sel < 10) begin
        repeat ($urandom_range(0, 12)) send_byte(8'($urandom_range(0, 255)), 1'b0);
        send_byte(($urandom_range(0, 1) != 0) ? SX_END : 8'($urandom_range(0, 255)), 1'b1);
      end else if (sel < 20) begin
        send_patch(name_n, $urandom_range(4, 80), 0, SUM_GOOD, $urandom_range(0, 3), SX_END);
      end else if (sel < 27) begin
        send_patch($urandom_range(NAME_MAX + 1, 255), $urandom_range(5, 60), 0, SUM_GOOD,
                   NO_FAULT, SX_END);
      end else if (sel < 33) begin
        send_patch(name_n, $urandom_range(0, 60), 0, SUM_GOOD, NO_FAULT,
                   8'($urandom_range(0, 255)));
      end else begin
        send_patch(name_n, $urandom_range(0, 70), 0, SUM_GOOD, NO_FAULT, SX_END);
      end
      msgs++;
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Run sequence
  // ---------------------------------------------------------------------------------------
  initial begin
    ids = '0;
    clear_message();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_register_extremes();
    test_long_message();
    test_random_messages();
    wait_idle();
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Guard against a hung handshake; the slowest correct run needs far less than this.
  initial begin
    #1_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
